// ----- src/nsd_pkg.sv -----
package nsd_pkg;

  // Image dimensions are limited to this many bits (8 to 32), and never beyond 16 bits.
  localparam int unsigned DIM_BITS = 16;
  localparam logic [15:0] DIM_MAX = (DIM_BITS >= 16) ? 16'hFFFF :
                                    16'((64'd1 << DIM_BITS) - 64'd1);

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_BAD_MAGIC = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_MAGIC_P     = 4'd0,
    PH_MAGIC_DIGIT = 4'd1,
    PH_WIDTH       = 4'd2,
    PH_HEIGHT      = 4'd3,
    PH_MAXVAL      = 4'd4,
    PH_TEXT        = 4'd5,
    PH_BIN_WAIT    = 4'd6,
    PH_BIN_DATA    = 4'd7,
    PH_HALTED      = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    IMG_BITMAP = 2'd0,
    IMG_GRAY   = 2'd1,
    IMG_PIXMAP = 2'd2
  } img_e;

  // All results caused by one byte: npix pixels on one row starting at column,
  // then an optional status result.
  typedef struct packed {
    logic [3:0]  npix;
    logic        mono;
    logic [7:0]  bits;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        alpha;
    logic [15:0] column;
    logic [15:0] row;
    logic        tail;
    kind_e       tail_kind;
  } burst_t;

  function automatic logic [15:0] dim_limit(input logic [15:0] v);
    dim_limit = (v > DIM_MAX) ? DIM_MAX : v;
  endfunction

endpackage

// ----- src/nsd_if.sv -----
interface nsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface nsd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        alpha;
  logic [15:0] column;
  logic [15:0] row;
  logic        last_of_run;

  modport source (output valid, output kind, output red, output green, output blue,
                  output alpha, output column, output row, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input red, input green, input blue,
                input alpha, input column, input row, input last_of_run,
                output ready);
endinterface

// ----- src/nsd_parser.sv -----
module nsd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  nsd_byte_if.sink        in_i,
  output nsd_pkg::burst_t burst_o,
  output logic            burst_valid_o,
  input  logic            burst_ready_i
);

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_eof_q;
  logic       s1_go;

  // Parser state.
  nsd_pkg::phase_e phase_q, phase_d;
  nsd_pkg::img_e   img_q, img_d;
  logic        binary_q, binary_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        wide_q, wide_d;
  logic [15:0] acc_q, acc_d;
  logic        have_digit_q, have_digit_d;
  logic        comment_q, comment_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [1:0]  chan_q, chan_d;
  logic [7:0]  held_red_q, held_red_d;
  logic [7:0]  held_green_q, held_green_d;
  logic        hi_pend_q, hi_pend_d;
  logic [7:0]  hi_byte_q, hi_byte_d;

  // Byte classification and number accumulation.
  logic        is_dig, is_spc, is_hsh, is_eol;
  logic [19:0] acc_prod;
  logic [15:0] acc_new;

  logic            num_end, num_hash, hdr_done;
  logic [15:0]     num_val;
  logic            smp_go;
  logic [15:0]     smp_val;
  logic [7:0]      smp8;
  logic            pix_go, p4_go;
  logic [7:0]      pix_r, pix_g, pix_b;
  logic            pix_a;
  logic [15:0]     rem;
  logic [3:0]      adv;
  logic            end_row;
  logic [16:0]     row_inc;
  logic            fail_go, done_go;
  nsd_pkg::kind_e  fail_kind;
  logic            has_results;

  assign is_dig = (s1_byte_q >= CH_ZERO) && (s1_byte_q <= CH_NINE);
  assign is_spc = (s1_byte_q == CH_SPACE) || ((s1_byte_q >= CH_TAB) && (s1_byte_q <= CH_CR));
  assign is_hsh = (s1_byte_q == CH_HASH);
  assign is_eol = (s1_byte_q == CH_LF) || (s1_byte_q == CH_CR);
  assign acc_prod = 20'(acc_q) * 20'd10 + 20'(s1_byte_q - CH_ZERO);
  assign acc_new  = (|acc_prod[19:16]) ? 16'hFFFF : acc_prod[15:0];
  assign rem      = width_q - col_q;
  assign row_inc  = 17'(row_q) + 17'd1;

  always_comb begin
    phase_d      = phase_q;
    img_d        = img_q;
    binary_d     = binary_q;
    width_d      = width_q;
    height_d     = height_q;
    wide_d       = wide_q;
    acc_d        = acc_q;
    have_digit_d = have_digit_q;
    comment_d    = comment_q;
    col_d        = col_q;
    row_d        = row_q;
    chan_d       = chan_q;
    held_red_d   = held_red_q;
    held_green_d = held_green_q;
    hi_pend_d    = hi_pend_q;
    hi_byte_d    = hi_byte_q;

    num_end   = 1'b0;
    num_val   = acc_q;
    num_hash  = 1'b0;
    hdr_done  = 1'b0;
    smp_go    = 1'b0;
    smp_val   = 16'd0;
    smp8      = 8'd0;
    pix_go    = 1'b0;
    p4_go     = 1'b0;
    pix_r     = 8'd0;
    pix_g     = 8'd0;
    pix_b     = 8'd0;
    pix_a     = 1'b0;
    adv       = 4'd0;
    end_row   = 1'b0;
    fail_go   = 1'b0;
    fail_kind = nsd_pkg::KIND_TRUNCATED;
    done_go   = 1'b0;

    unique case (phase_q)
      nsd_pkg::PH_MAGIC_P: begin
        if (s1_byte_q == CH_P) begin
          phase_d = nsd_pkg::PH_MAGIC_DIGIT;
        end else begin
          fail_go   = 1'b1;
          fail_kind = nsd_pkg::KIND_BAD_MAGIC;
        end
      end
      nsd_pkg::PH_MAGIC_DIGIT: begin
        if ((s1_byte_q >= CH_ONE) && (s1_byte_q <= CH_SIX)) begin
          binary_d = (s1_byte_q >= CH_FOUR);
          phase_d  = nsd_pkg::PH_WIDTH;
          if ((s1_byte_q == CH_ONE) || (s1_byte_q == CH_FOUR)) begin
            img_d = nsd_pkg::IMG_BITMAP;
          end else if ((s1_byte_q == CH_TWO) || (s1_byte_q == CH_FIVE)) begin
            img_d = nsd_pkg::IMG_GRAY;
          end else begin
            img_d = nsd_pkg::IMG_PIXMAP;
          end
        end else begin
          fail_go   = 1'b1;
          fail_kind = nsd_pkg::KIND_BAD_MAGIC;
        end
      end
      nsd_pkg::PH_WIDTH, nsd_pkg::PH_HEIGHT, nsd_pkg::PH_MAXVAL, nsd_pkg::PH_TEXT: begin
        if (comment_q) begin
          if (is_eol) begin
            comment_d = 1'b0;
          end
        end else if (is_dig) begin
          if ((phase_q == nsd_pkg::PH_TEXT) && (img_q == nsd_pkg::IMG_BITMAP)) begin
            pix_go = 1'b1;
            pix_r  = (s1_byte_q != CH_ZERO) ? 8'hFF : 8'h00;
            pix_g  = pix_r;
            pix_b  = pix_r;
          end else begin
            acc_d        = acc_new;
            have_digit_d = 1'b1;
            // A number still open at the end of the file is closed as if by a space.
            if (s1_eof_q) begin
              num_end = 1'b1;
              num_val = acc_new;
            end
          end
        end else if (is_spc || is_hsh) begin
          if (phase_q == nsd_pkg::PH_TEXT) begin
            if (is_hsh) begin
              comment_d = 1'b1;
            end
          end else begin
            comment_d = is_hsh;
          end
          if (have_digit_q) begin
            num_end      = 1'b1;
            num_val      = acc_q;
            num_hash     = is_hsh;
            acc_d        = 16'd0;
            have_digit_d = 1'b0;
          end
        end else begin
          fail_go = 1'b1;
        end
      end
      nsd_pkg::PH_BIN_WAIT: begin
        if (is_eol) begin
          comment_d = 1'b0;
          phase_d   = nsd_pkg::PH_BIN_DATA;
        end
      end
      nsd_pkg::PH_BIN_DATA: begin
        if (img_q == nsd_pkg::IMG_BITMAP) begin
          p4_go = 1'b1;
        end else if (wide_q) begin
          if (!hi_pend_q) begin
            hi_byte_d = s1_byte_q;
            hi_pend_d = 1'b1;
          end else begin
            hi_pend_d = 1'b0;
            smp_go    = 1'b1;
            smp_val   = {hi_byte_q, s1_byte_q};
          end
        end else begin
          smp_go  = 1'b1;
          smp_val = {8'd0, s1_byte_q};
        end
      end
      nsd_pkg::PH_HALTED: begin
      end
      default: begin
        phase_d = nsd_pkg::PH_HALTED;
      end
    endcase

    // A finished decimal number.
    if (num_end) begin
      unique case (phase_q)
        nsd_pkg::PH_WIDTH: begin
          width_d = nsd_pkg::dim_limit(num_val);
          phase_d = nsd_pkg::PH_HEIGHT;
        end
        nsd_pkg::PH_HEIGHT: begin
          height_d = nsd_pkg::dim_limit(num_val);
          if (img_q == nsd_pkg::IMG_BITMAP) begin
            hdr_done = 1'b1;
          end else begin
            phase_d = nsd_pkg::PH_MAXVAL;
          end
        end
        nsd_pkg::PH_MAXVAL: begin
          wide_d   = |num_val[15:8];
          hdr_done = 1'b1;
        end
        default: begin
          smp_go  = 1'b1;
          smp_val = num_val;
        end
      endcase
    end

    if (hdr_done) begin
      if (binary_q) begin
        phase_d = num_hash ? nsd_pkg::PH_BIN_WAIT : nsd_pkg::PH_BIN_DATA;
      end else begin
        phase_d = nsd_pkg::PH_TEXT;
      end
      if ((width_d == 16'd0) || (height_d == 16'd0)) begin
        done_go = 1'b1;
        phase_d = nsd_pkg::PH_HALTED;
      end
    end

    // One sample becomes a pixel, or is held as a pixmap channel.
    if (smp_go) begin
      if (wide_q) begin
        smp8 = smp_val[15:8];
      end else begin
        smp8 = (|smp_val[15:8]) ? 8'hFF : smp_val[7:0];
      end
      if (img_q == nsd_pkg::IMG_PIXMAP) begin
        if (chan_q == 2'd0) begin
          held_red_d = smp8;
          chan_d     = 2'd1;
        end else if (chan_q == 2'd1) begin
          held_green_d = smp8;
          chan_d       = 2'd2;
        end else begin
          chan_d = 2'd0;
          pix_go = 1'b1;
          pix_r  = held_red_q;
          pix_g  = held_green_q;
          pix_b  = smp8;
          pix_a  = (held_red_q == 8'hFF) && (held_green_q == 8'hFF) && (smp8 == 8'hFF);
        end
      end else begin
        pix_go = 1'b1;
        pix_r  = smp8;
        pix_g  = smp8;
        pix_b  = smp8;
      end
    end

    // Position advance; a packed bitmap byte stops at the end of its row.
    if (pix_go || p4_go) begin
      if (p4_go) begin
        adv = (rem >= 16'd8) ? 4'd8 : rem[3:0];
      end else begin
        adv = 4'd1;
      end
      end_row = (rem <= 16'(adv));
      if (end_row) begin
        col_d = 16'd0;
        row_d = row_inc[15:0];
        if (row_inc >= 17'(height_q)) begin
          done_go = 1'b1;
          phase_d = nsd_pkg::PH_HALTED;
        end
      end else begin
        col_d = col_q + 16'(adv);
      end
    end

    if (fail_go) begin
      phase_d = nsd_pkg::PH_HALTED;
    end

    // The last byte of a file closes the image and restarts the parser.
    if (s1_eof_q) begin
      if (phase_d != nsd_pkg::PH_HALTED) begin
        fail_go = 1'b1;
        if ((phase_d == nsd_pkg::PH_MAGIC_P) || (phase_d == nsd_pkg::PH_MAGIC_DIGIT)) begin
          fail_kind = nsd_pkg::KIND_BAD_MAGIC;
        end else begin
          fail_kind = nsd_pkg::KIND_TRUNCATED;
        end
      end
      phase_d      = nsd_pkg::PH_MAGIC_P;
      img_d        = nsd_pkg::IMG_BITMAP;
      binary_d     = 1'b0;
      width_d      = 16'd0;
      height_d     = 16'd0;
      wide_d       = 1'b0;
      acc_d        = 16'd0;
      have_digit_d = 1'b0;
      comment_d    = 1'b0;
      col_d        = 16'd0;
      row_d        = 16'd0;
      chan_d       = 2'd0;
      held_red_d   = 8'd0;
      held_green_d = 8'd0;
      hi_pend_d    = 1'b0;
      hi_byte_d    = 8'd0;
    end
  end

  always_comb begin
    burst_o.npix      = pix_go ? 4'd1 : (p4_go ? adv : 4'd0);
    burst_o.mono      = p4_go;
    burst_o.bits      = s1_byte_q;
    burst_o.red       = pix_r;
    burst_o.green     = pix_g;
    burst_o.blue      = pix_b;
    burst_o.alpha     = pix_a;
    burst_o.column    = col_q;
    burst_o.row       = row_q;
    burst_o.tail      = fail_go || done_go;
    burst_o.tail_kind = fail_go ? fail_kind : nsd_pkg::KIND_DONE;
  end

  assign has_results   = pix_go || p4_go || fail_go || done_go;
  assign burst_valid_o = s1_valid_q && has_results;
  assign s1_go         = s1_valid_q && (!has_results || burst_ready_i);
  assign in_i.ready    = !s1_valid_q || s1_go;

  always_comb begin
    if (in_i.valid && in_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_eof_q  <= in_i.end_of_file;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      phase_q      <= nsd_pkg::PH_MAGIC_P;
      img_q        <= nsd_pkg::IMG_BITMAP;
      binary_q     <= 1'b0;
      width_q      <= 16'd0;
      height_q     <= 16'd0;
      wide_q       <= 1'b0;
      acc_q        <= 16'd0;
      have_digit_q <= 1'b0;
      comment_q    <= 1'b0;
      col_q        <= 16'd0;
      row_q        <= 16'd0;
      chan_q       <= 2'd0;
      held_red_q   <= 8'd0;
      held_green_q <= 8'd0;
      hi_pend_q    <= 1'b0;
      hi_byte_q    <= 8'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_go) begin
        phase_q      <= phase_d;
        img_q        <= img_d;
        binary_q     <= binary_d;
        width_q      <= width_d;
        height_q     <= height_d;
        wide_q       <= wide_d;
        acc_q        <= acc_d;
        have_digit_q <= have_digit_d;
        comment_q    <= comment_d;
        col_q        <= col_d;
        row_q        <= row_d;
        chan_q       <= chan_d;
        held_red_q   <= held_red_d;
        held_green_q <= held_green_d;
        hi_pend_q    <= hi_pend_d;
        hi_byte_q    <= hi_byte_d;
      end
    end
  end

endmodule

// ----- src/nsd_emitter.sv -----
module nsd_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nsd_pkg::burst_t burst_i,
  input  logic            burst_valid_i,
  output logic            burst_ready_o,
  nsd_result_if.source    out_o
);

  logic            busy_q, busy_d;
  logic [3:0]      npix_q;
  logic            mono_q;
  logic [7:0]      bits_q;
  logic [7:0]      red_q, green_q, blue_q;
  logic            alpha_q;
  logic [15:0]     col_q;
  logic [15:0]     row_q;
  logic            tail_q;
  nsd_pkg::kind_e  tail_kind_q;

  logic pix_mode, last, fire, load;

  assign pix_mode = (npix_q != 4'd0);
  assign last     = pix_mode ? ((npix_q == 4'd1) && !tail_q) : 1'b1;
  assign fire     = busy_q && out_o.ready;
  assign burst_ready_o = !busy_q || (fire && last);
  assign load     = burst_valid_i && burst_ready_o;

  always_comb begin
    out_o.valid       = busy_q;
    out_o.last_of_run = last;
    if (pix_mode) begin
      out_o.kind   = nsd_pkg::KIND_PIXEL;
      out_o.red    = mono_q ? {8{bits_q[7]}} : red_q;
      out_o.green  = mono_q ? {8{bits_q[7]}} : green_q;
      out_o.blue   = mono_q ? {8{bits_q[7]}} : blue_q;
      out_o.alpha  = mono_q ? 1'b0 : alpha_q;
      out_o.column = col_q;
      out_o.row    = row_q;
    end else begin
      out_o.kind   = tail_kind_q;
      out_o.red    = 8'd0;
      out_o.green  = 8'd0;
      out_o.blue   = 8'd0;
      out_o.alpha  = 1'b0;
      out_o.column = 16'd0;
      out_o.row    = 16'd0;
    end
  end

  always_comb begin
    if (load) begin
      busy_d = 1'b1;
    end else if (fire && last) begin
      busy_d = 1'b0;
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      npix_q <= 4'd0;
    end else begin
      busy_q <= busy_d;
      if (load) begin
        npix_q <= burst_i.npix;
      end else if (fire && pix_mode) begin
        npix_q <= npix_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mono_q      <= burst_i.mono;
      bits_q      <= burst_i.bits;
      red_q       <= burst_i.red;
      green_q     <= burst_i.green;
      blue_q      <= burst_i.blue;
      alpha_q     <= burst_i.alpha;
      col_q       <= burst_i.column;
      row_q       <= burst_i.row;
      tail_q      <= burst_i.tail;
      tail_kind_q <= burst_i.tail_kind;
    end else if (fire && pix_mode) begin
      // Packed bitmap pixels leave most significant bit first.
      bits_q <= {bits_q[6:0], 1'b0};
      col_q  <= col_q + 16'd1;
    end
  end

endmodule

// ----- src/netpbm_stream_decoder.sv -----
// Netpbm (P1 to P6) decoder taking one file byte per request and returning
// 8-bit RGB pixels with a one-bit alpha, column and row, then an
// image-complete, bad-magic or truncated status; the request that carries
// end_of_file always leaves the decoder ready for a new file. A byte is
// registered at the input, parsed and its results are handed as one group to
// the result stage, which delivers one result per cycle while the output is
// ready. Bytes with at most one result can therefore arrive back to back; a
// byte with more results (a packed P4 byte gives up to eight pixels plus a
// status) keeps the result stage busy, and a following byte with results
// waits in the input register until they have all been delivered.
module netpbm_stream_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  nsd_byte_if.sink      in_i,
  nsd_result_if.source  out_o
);

  nsd_pkg::burst_t burst;
  logic            burst_valid;
  logic            burst_ready;

  nsd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .burst_o       (burst),
    .burst_valid_o (burst_valid),
    .burst_ready_i (burst_ready)
  );

  nsd_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_i       (burst),
    .burst_valid_i (burst_valid),
    .burst_ready_o (burst_ready),
    .out_o         (out_o)
  );

endmodule
